FILE: rtl/utlc_pkg.sv
// Shared types, constants and calendar helpers for the UTC-to-local converter.
package utlc_pkg;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_ZONE_IDX = 1'b0;

   localparam logic [7:0] ZONE_RESET = 8'h00;

   typedef struct packed {
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } utc_type;

   typedef struct packed {
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } local_type;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 40;

   function automatic logic is_leap(input logic [7:0] yr);
      return (yr[1:0] == 2'b00);
   endfunction

   function automatic logic is_short_month(input logic [7:0] mo);
      return (mo == 8'd4) || (mo == 8'd6) || (mo == 8'd9) || (mo == 8'd11);
   endfunction

   function automatic logic [7:0] quarter_minutes(input logic [1:0] code);
      logic [7:0] q;
      unique case (code)
         2'd1: q = 8'd15;
         2'd2: q = 8'd30;
         2'd3: q = 8'd45;
         default: q = 8'd0;
      endcase
      return q;
   endfunction

endpackage

FILE: rtl/utc_to_local_time_with_calendar.sv
// Top level: UTC timestamp stream in, local timestamp stream out, zone register.
//
// Usage:
//   req_ stream carries one UTC timestamp per item; rsp_ stream returns the
//   local timestamp for it, one result per item, in order.
//   The zone register (byte address 0 of the csr_ port) holds the offset:
//   bit 7 add/subtract, bits 6:5 quarter hours, bits 4:0 whole hours.
//   Write it only while no item is in flight.
// Pipeline:
//   An item is captured in the input register, converted by the calendar
//   logic and loaded into the result register.
//   One item per cycle is accepted steadily while rsp_tready stays high;
//   the two registers form a two-deep pipeline.
// Reset:
//   Both stages are emptied and the zone register returns to 0 (UTC).
// Stall:
//   While rsp_tready is low the result holds; the input register keeps one
//   more item, then req_tready drops until the output drains.
module utc_to_local_time_with_calendar
   import utlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // year[7:0], month[11:8], day[16:12], hour[21:17], minute[27:22], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // year[7:0], month[15:8], day[23:16], hour[31:24], minute[39:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0] zone_ff;
   logic [7:0] zone_in;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   utc_type    s1_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   local_type  rsp_data_ff;
   local_type  calc_out;
   logic       s1_advance;
   logic       req_take;
   logic       csr_wr;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_ZONE_IDX);
   assign zone_in    = csr_wr ? csr_pwdata[7:0] : zone_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_ZONE_IDX) ? {24'd0, zone_ff} : '0;

   // pipeline control
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_advance;
   assign req_take     = req_tvalid && req_tready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);

   utlc_calc u_calc (
      .utc  (s1_data_ff),
      .zone (zone_ff),
      .loc  (calc_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff      <= ZONE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         zone_ff      <= zone_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= utc_type'({req_tdata[27:22], req_tdata[21:17], req_tdata[16:12],
                                  req_tdata[11:8], req_tdata[7:0]});
      end
      if (s1_advance) begin
         rsp_data_ff <= calc_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.minute, rsp_data_ff.hour, rsp_data_ff.day,
                        rsp_data_ff.month, rsp_data_ff.year};

`ifndef ASSERT_OFF
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted item not held in input stage");

   a_s1_moves_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_tready |=> rsp_valid_ff)
      else $error("input stage did not move to result register");

   a_block_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff)
      else $error("input blocked while pipeline not full");

   a_zone_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_wr) |-> $stable(zone_ff))
      else $error("zone register changed without a write");
`endif

endmodule

FILE: rtl/utlc_calc.sv
// Zone offset and one-day calendar rollover for one timestamp.
module utlc_calc
   import utlc_pkg::*;
(
   input  utc_type    utc,
   input  logic [7:0] zone,
   output local_type  loc
);

   always_comb begin
      logic [7:0] yr;
      logic [7:0] mo;
      logic [7:0] dy;
      logic [7:0] hr;
      logic [7:0] mn;
      logic [7:0] zh;
      logic [7:0] qmin;
      logic       fwd;
      logic       back;
      logic       cy;

      yr   = utc.year;
      mo   = {4'd0, utc.month};
      dy   = {3'd0, utc.day};
      hr   = {3'd0, utc.hour};
      mn   = {2'd0, utc.minute};
      zh   = {3'd0, zone[4:0]};
      qmin = quarter_minutes(zone[6:5]);
      fwd  = 1'b0;
      back = 1'b0;
      cy   = 1'b0;

      if (zone[7]) begin
         mn = mn + qmin;
         if (mn > 8'd59) begin
            mn = mn - 8'd60;
            cy = 1'b1;
         end
         hr = hr + zh + {7'd0, cy};
         if (hr > 8'd23) begin
            hr  = hr - 8'd24;
            fwd = 1'b1;
         end
      end else begin
         if (mn < qmin) begin
            mn = mn + 8'd60;
            cy = 1'b1;
         end
         mn = mn - qmin;
         hr = 8'd24 + hr - zh - {7'd0, cy};
         if (hr > 8'd23) begin
            hr = hr - 8'd24;
         end else begin
            back = 1'b1;
         end
      end

      if (fwd) begin
         dy = dy + 8'd1;
         priority if (dy == 8'd29 && mo == 8'd2 && !is_leap(yr)) begin
            dy = 8'd1;
            mo = 8'd3;
         end else if (dy == 8'd30 && mo == 8'd2 && is_leap(yr)) begin
            dy = 8'd1;
            mo = 8'd3;
         end else if (dy == 8'd31 && is_short_month(mo)) begin
            dy = 8'd1;
            mo = mo + 8'd1;
         end else if (dy >= 8'd32) begin
            dy = 8'd1;
            mo = mo + 8'd1;
            if (mo > 8'd12) begin
               mo = 8'd1;
               yr = yr + 8'd1;
            end
         end else begin
            dy = dy;
         end
      end else if (back) begin
         dy = dy - 8'd1;
         if (dy == 8'd0) begin
            dy = 8'd31;
            mo = mo - 8'd1;
            priority if (mo == 8'd0) begin
               mo = 8'd12;
               yr = yr - 8'd1;
            end else if (mo == 8'd2) begin
               dy = is_leap(yr) ? 8'd29 : 8'd28;
            end else if (is_short_month(mo)) begin
               dy = 8'd30;
            end else begin
               dy = dy;
            end
         end
      end

      loc.year   = yr;
      loc.month  = mo;
      loc.day    = dy;
      loc.hour   = hr;
      loc.minute = mn;
   end

endmodule
